// ===== sv/lcdxp_pkg.sv =====
`default_nettype none

package lcdxp_pkg;

  // input action codes
  typedef enum logic [2:0] {
    ACT_PREPARE   = 3'd0,
    ACT_INSTR8    = 3'd1,
    ACT_INSTR4    = 3'd2,
    ACT_DATA4     = 3'd3,
    ACT_BACKLIGHT = 3'd4,
    ACT_TICK      = 3'd5
  } act_e;

  // sequences the back end knows how to play out
  typedef enum logic [2:0] {
    OP_PREPARE = 3'd0,
    OP_INSTR8  = 3'd1,
    OP_INSTR4  = 3'd2,
    OP_DATA4   = 3'd3,
    OP_BL_ON   = 3'd4,
    OP_BL_OFF  = 3'd5
  } op_e;

  // one queued command
  typedef struct packed {
    op_e        op;
    logic [7:0] value;
  } cmd_t;

  // expander port bit positions
  localparam int unsigned RsBit = 0;
  localparam int unsigned RwBit = 1;
  localparam int unsigned EBit  = 2;
  localparam int unsigned BlBit = 3;

  // backlight pwm constants
  localparam logic [31:0] SlotUs     = 32'd100;
  localparam logic [6:0]  NumSlots   = 7'd100;
  localparam logic [6:0]  DutyWrap   = 7'd99;
  localparam logic [6:0]  DutyFirst  = 7'd1;
  localparam logic [6:0]  DutyReset  = 7'd10;
  localparam logic [15:0] RampReset  = 16'd10;

  // step numbers inside the sequences
  localparam logic [3:0] InstrNibSteps = 4'd5;
  localparam logic [3:0] DataNibSteps  = 4'd3;
  localparam logic [3:0] PrepLast      = 4'd1;
  localparam logic [3:0] Instr8Last    = 4'd4;
  localparam logic [3:0] Instr4Last    = 4'd9;
  localparam logic [3:0] Data4Last     = 4'd5;

endpackage

`default_nettype wire

// ===== sv/lcdxp_ifs.sv =====
`default_nettype none

// command channel
interface lcdxp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  value;
  logic [31:0] now_us;
  logic [31:0] now_ms;

  modport source (output valid, action, value, now_us, now_ms, input ready);
  modport sink   (input valid, action, value, now_us, now_ms, output ready);
endinterface

// expander byte channel
interface lcdxp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;
  logic       settle_after;
  logic       last;

  modport source (output valid, expander_byte, settle_after, last, input ready);
  modport sink   (input valid, expander_byte, settle_after, last, output ready);
endinterface

`default_nettype wire

// ===== sv/lcdxp_front.sv =====
`default_nettype none

module lcdxp_front
  import lcdxp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  lcdxp_in_if.sink         in_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [15:0] ramp_period_q;
  logic [31:0] last_slot_us_q, last_slot_us_d;
  logic [31:0] last_ramp_ms_q, last_ramp_ms_d;
  logic [6:0]  slot_count_q, slot_count_d;
  logic [6:0]  duty_slots_q, duty_slots_d;
  logic        accept;
  logic        is_tick;
  logic [31:0] us_diff;
  logic [31:0] ms_diff;
  logic [6:0]  duty_inc;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // elapsed time since the last slot and the last ramp step
  assign us_diff  = in_i.now_us - last_slot_us_q;
  assign ms_diff  = in_i.now_ms - last_ramp_ms_q;
  assign duty_inc = duty_slots_q + 7'd1;

  // classify the beat and run the pwm bookkeeping for ticks
  always_comb begin
    push_o         = 1'b0;
    cmd_o.op       = OP_PREPARE;
    cmd_o.value    = in_i.value;
    is_tick        = 1'b0;
    last_slot_us_d = last_slot_us_q;
    last_ramp_ms_d = last_ramp_ms_q;
    slot_count_d   = slot_count_q;
    duty_slots_d   = duty_slots_q;
    case (act_e'(in_i.action))
      ACT_PREPARE: begin
        push_o   = 1'b1;
        cmd_o.op = OP_PREPARE;
      end
      ACT_INSTR8: begin
        push_o   = 1'b1;
        cmd_o.op = OP_INSTR8;
      end
      ACT_INSTR4: begin
        push_o   = 1'b1;
        cmd_o.op = OP_INSTR4;
      end
      ACT_DATA4: begin
        push_o   = 1'b1;
        cmd_o.op = OP_DATA4;
      end
      ACT_BACKLIGHT: begin
        if (in_i.value == 8'd1) begin
          push_o   = 1'b1;
          cmd_o.op = OP_BL_ON;
        end else if (in_i.value == 8'd0) begin
          push_o   = 1'b1;
          cmd_o.op = OP_BL_OFF;
        end
      end
      ACT_TICK: begin
        is_tick = 1'b1;
        if (us_diff > SlotUs) begin
          last_slot_us_d = in_i.now_us;
          if (slot_count_q == NumSlots) begin
            push_o       = 1'b1;
            cmd_o.op     = OP_BL_ON;
            slot_count_d = 7'd1;
          end else begin
            if (slot_count_q == duty_slots_q) begin
              push_o   = 1'b1;
              cmd_o.op = OP_BL_OFF;
            end
            slot_count_d = slot_count_q + 7'd1;
          end
        end
        if (ms_diff > {16'd0, ramp_period_q}) begin
          last_ramp_ms_d = in_i.now_ms;
          duty_slots_d   = (duty_inc == DutyWrap) ? DutyFirst : duty_inc;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    push_o = push_o && accept;
  end

  // configuration and pwm state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_period_q  <= RampReset;
      last_slot_us_q <= '0;
      last_ramp_ms_q <= '0;
      slot_count_q   <= '0;
      duty_slots_q   <= DutyReset;
    end else begin
      if (cfg_we_i) begin
        ramp_period_q <= cfg_wdata_i;
      end
      if (accept && is_tick) begin
        last_slot_us_q <= last_slot_us_d;
        last_ramp_ms_q <= last_ramp_ms_d;
        slot_count_q   <= slot_count_d;
        duty_slots_q   <= duty_slots_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lcdxp_cmd_fifo.sv =====
`default_nettype none

module lcdxp_cmd_fifo
  import lcdxp_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output cmd_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (count_q == CntFull);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lcdxp_back.sv =====
`default_nettype none

module lcdxp_back
  import lcdxp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic head_valid_i,
  input  wire cmd_t head_i,
  output logic      pop_o,
  lcdxp_out_if.source out_o
);

  logic [7:0] shadow_q, shadow_d;
  logic [3:0] step_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_settle_q;
  logic       out_last_q;
  logic       advance;
  logic       settle;
  logic       is_last;
  logic [3:0] sub;
  logic [3:0] nib;

  assign advance = head_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o   = advance && is_last;

  assign out_o.valid         = out_valid_q;
  assign out_o.expander_byte = out_byte_q;
  assign out_o.settle_after  = out_settle_q;
  assign out_o.last          = out_last_q;

  // next shadow byte for the current step of the head command
  always_comb begin
    shadow_d = shadow_q;
    settle   = 1'b0;
    is_last  = 1'b0;
    sub      = step_q;
    nib      = head_i.value[7:4];
    case (head_i.op)
      OP_PREPARE: begin
        if (step_q == 4'd0) begin
          shadow_d[RsBit] = 1'b1;
        end else begin
          shadow_d[RwBit] = 1'b0;
        end
        is_last = (step_q == PrepLast);
      end
      OP_INSTR8, OP_INSTR4: begin
        if (step_q >= InstrNibSteps) begin
          sub = step_q - InstrNibSteps;
          nib = head_i.value[3:0];
        end
        case (sub)
          4'd0:    shadow_d[RsBit] = 1'b0;
          4'd1:    shadow_d[7:4]   = nib;
          4'd2:    shadow_d[EBit]  = 1'b1;
          4'd3:    shadow_d[EBit]  = 1'b0;
          default: begin
            shadow_d[RsBit] = 1'b1;
            settle          = 1'b1;
          end
        endcase
        is_last = (head_i.op == OP_INSTR8) ? (step_q == Instr8Last)
                                           : (step_q == Instr4Last);
      end
      OP_DATA4: begin
        if (step_q >= DataNibSteps) begin
          sub = step_q - DataNibSteps;
          nib = head_i.value[3:0];
        end
        case (sub)
          4'd0:    shadow_d[7:4]  = nib;
          4'd1:    shadow_d[EBit] = 1'b1;
          default: begin
            shadow_d[EBit] = 1'b0;
            settle         = 1'b1;
          end
        endcase
        is_last = (step_q == Data4Last);
      end
      OP_BL_ON: begin
        shadow_d[BlBit] = 1'b1;
        is_last         = 1'b1;
      end
      OP_BL_OFF: begin
        shadow_d[BlBit] = 1'b0;
        is_last         = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  // sequencer state, shadow byte and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        shadow_q    <= shadow_d;
        step_q      <= is_last ? 4'd0 : step_q + 4'd1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q   <= shadow_d;
      out_settle_q <= settle;
      out_last_q   <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lcd_expander_nibble_sequencer_core.sv =====
// LCD command sequencer for an 8-bit I/O expander driving a character LCD in
// 4-bit mode. Commands come in on in_i (action, value, timestamps); expander
// bytes go out on out_o, one byte per beat, with settle_after marking a wait
// and last marking the final byte of a command.
// A front end classifies each command and runs the backlight pwm timing; it
// pushes a sequence into a small command queue (QueueDepth entries). The back
// end plays one sequence step per cycle, unless out_o stalls, into an output
// register. The first byte of a command passes through the queue entry and
// then the output register before it is valid on out_o.
// Throughput: one output byte per cycle while out_o is not stalled. Bytes per
// command: 2 (prepare), 5 (8-bit instruction), 10 (4-bit instruction),
// 6 (data), 1 (backlight, or a tick that switches the backlight).
// Commands that make no byte are absorbed by the front end.
// in_i.ready drops only while the queue is full.
// When out_o is stalled the output byte holds and the back end waits; the
// queue keeps taking commands until it fills.
// Reset clears the shadow port byte and pwm state, sets the ramp period to
// 10 ms and the duty to 10 slots. cfg_we_i/cfg_wdata_i write the ramp period.
`default_nettype none

module lcd_expander_nibble_sequencer_core
  import lcdxp_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  lcdxp_in_if.sink         in_i,
  lcdxp_out_if.source      out_o
);

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // command classification and pwm timing
  lcdxp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // queue between front and back
  lcdxp_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // byte sequencer
  lcdxp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/lcdxp_seq_checker.sv =====
module lcdxp_seq_checker
  import lcdxp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  lcdxp_in_if         cmd_i,
  lcdxp_out_if        port_i,
  output int          errors_o,
  output int          pending_o,
  output int          bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] port_byte;
    logic       settle;
    logic       last;
  } port_beat_t;

  // expander bytes still owed by the block, oldest first
  port_beat_t  port_beats_q[$];

  // own copy of the expander shadow, pwm state and ramp period
  logic [7:0]  shadow;
  logic [31:0] slot_stamp_us;
  logic [31:0] ramp_stamp_ms;
  logic [6:0]  slot_idx;
  logic [6:0]  duty;
  logic [15:0] ramp_ms;
  int          err_cnt;
  int          byte_cnt;

  task automatic push_byte(input logic settle);
    port_beat_t b;
    b.port_byte = shadow;
    b.settle    = settle;
    b.last      = 1'b0;
    port_beats_q.push_back(b);
  endtask

  // instruction nibble: rs low around the e strobe, settle after rs returns
  task automatic instr_nibble(input logic [3:0] nib);
    shadow[RsBit] = 1'b0;
    push_byte(1'b0);
    shadow[7:4] = nib;
    push_byte(1'b0);
    shadow[EBit] = 1'b1;
    push_byte(1'b0);
    shadow[EBit] = 1'b0;
    push_byte(1'b0);
    shadow[RsBit] = 1'b1;
    push_byte(1'b1);
  endtask

  // data nibble: rs untouched
  task automatic data_nibble(input logic [3:0] nib);
    shadow[7:4] = nib;
    push_byte(1'b0);
    shadow[EBit] = 1'b1;
    push_byte(1'b0);
    shadow[EBit] = 1'b0;
    push_byte(1'b1);
  endtask

  task automatic drive_backlight(input logic on);
    shadow[BlBit] = on;
    push_byte(1'b0);
  endtask

  task automatic predict_command(input logic [2:0] action, input logic [7:0] value,
                                 input logic [31:0] us, input logic [31:0] ms);
    port_beat_t  tail;
    int          base;
    logic [31:0] us_gap;
    logic [31:0] ms_gap;
    base   = port_beats_q.size();
    us_gap = us - slot_stamp_us;
    ms_gap = ms - ramp_stamp_ms;
    case (action)
      ACT_PREPARE: begin
        shadow[RsBit] = 1'b1;
        push_byte(1'b0);
        shadow[RwBit] = 1'b0;
        push_byte(1'b0);
      end
      ACT_INSTR8: instr_nibble(value[7:4]);
      ACT_INSTR4: begin
        instr_nibble(value[7:4]);
        instr_nibble(value[3:0]);
      end
      ACT_DATA4: begin
        data_nibble(value[7:4]);
        data_nibble(value[3:0]);
      end
      ACT_BACKLIGHT: begin
        if (value == 8'd1) drive_backlight(1'b1);
        else if (value == 8'd0) drive_backlight(1'b0);
      end
      ACT_TICK: begin
        // pwm slot boundary, wrapping timestamp difference
        if (us_gap > SlotUs) begin
          slot_stamp_us = us;
          if (slot_idx == NumSlots) begin
            slot_idx = '0;
            drive_backlight(1'b1);
          end else if (slot_idx == duty) begin
            drive_backlight(1'b0);
          end
          slot_idx = slot_idx + 7'd1;
        end
        // duty ramp
        if (ms_gap > {16'd0, ramp_ms}) begin
          ramp_stamp_ms = ms;
          duty = duty + 7'd1;
          if (duty == DutyWrap) duty = DutyFirst;
        end
      end
      default: ;
    endcase
    // flag the final byte of this command
    if (port_beats_q.size() > base) begin
      tail = port_beats_q.pop_back();
      tail.last = 1'b1;
      port_beats_q.push_back(tail);
    end
  endtask

  task automatic field_check(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    port_beat_t want;
    if (!rst_ni) begin
      shadow        = '0;
      slot_stamp_us = '0;
      ramp_stamp_ms = '0;
      slot_idx      = '0;
      duty          = DutyReset;
      ramp_ms       = RampReset;
      err_cnt       = 0;
      byte_cnt      = 0;
      port_beats_q.delete();
    end else begin
      if (cfg_we_i) ramp_ms = cfg_wdata_i;
      if (cmd_i.valid && cmd_i.ready)
        predict_command(cmd_i.action, cmd_i.value, cmd_i.now_us, cmd_i.now_ms);
      if (port_i.valid && port_i.ready) begin
        byte_cnt++;
        if (port_beats_q.size() == 0) begin
          err_cnt++;
          $display("%0t: beat with byte %h settle %b last %b, expected none",
                   $time, port_i.expander_byte, port_i.settle_after, port_i.last);
        end else begin
          want = port_beats_q.pop_front();
          field_check("expander_byte", want.port_byte, port_i.expander_byte);
          field_check("settle_after", {7'd0, want.settle}, {7'd0, port_i.settle_after});
          field_check("last", {7'd0, want.last}, {7'd0, port_i.last});
        end
      end
    end
    errors_o  <= err_cnt;
    pending_o <= port_beats_q.size();
    bytes_o   <= byte_cnt;
  end

endmodule

// ===== tb/sv/tb_lcd_expander_nibble_sequencer_core.sv =====
module tb_lcd_expander_nibble_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdxp_pkg::*;

  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 12;
  localparam int RunLimitNs   = 2_000_000;
  // action codes the block must ignore
  localparam logic [2:0] ActSpareLo = 3'd6;
  localparam logic [2:0] ActSpareHi = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  lcdxp_in_if  cmd_if ();
  lcdxp_out_if port_if ();

  int          chk_errors;
  int          chk_pending;
  int          chk_bytes;

  // stimulus state
  int          cmds_sent;
  int          ramp_writes;
  int          tick_pct;
  int          ms_step_max;
  logic        calm;
  logic        hold_off_req;
  logic [31:0] us_now;
  logic [31:0] ms_now;

  lcd_expander_nibble_sequencer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cmd_if),
    .out_o       (port_if)
  );

  lcdxp_seq_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_if),
    .port_i      (port_if),
    .errors_o    (chk_errors),
    .pending_o   (chk_pending),
    .bytes_o     (chk_bytes)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // offer one command beat and wait for it to be taken
  task automatic send_cmd(input logic [2:0] action, input logic [7:0] value,
                          input logic [31:0] us, input logic [31:0] ms);
    while (!calm && $urandom_range(99) < 6) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.action <= action;
    cmd_if.value  <= value;
    cmd_if.now_us <= us;
    cmd_if.now_ms <= ms;
    @(posedge clk_i);
    while (cmd_if.ready !== 1'b1) @(posedge clk_i);
    if (action <= ACT_TICK && !(action == ACT_BACKLIGHT && value > 8'd1)) cmds_sent++;
  endtask

  // quiet point: everything delivered and the front end settled
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ramp(input logic [15:0] ramp);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= ramp;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    ramp_writes++;
  endtask

  task automatic send_random_cmd();
    int         pick;
    logic [7:0] v;
    logic [2:0] act;
    v = $urandom_range(255);
    if ($urandom_range(99) < tick_pct) begin
      // timestamps mostly walk forward, now and then jump anywhere
      if ($urandom_range(99) < 3) us_now = $urandom();
      else us_now = us_now + $urandom_range(260, 40);
      if ($urandom_range(99) < 3) ms_now = $urandom();
      else ms_now = ms_now + $urandom_range(ms_step_max);
      send_cmd(ACT_TICK, v, us_now, ms_now);
    end else begin
      pick = $urandom_range(99);
      if (pick < 15) act = ACT_PREPARE;
      else if (pick < 33) act = ACT_INSTR8;
      else if (pick < 55) act = ACT_INSTR4;
      else if (pick < 77) act = ACT_DATA4;
      else if (pick < 92) act = ACT_BACKLIGHT;
      else if (pick < 96) act = ActSpareLo;
      else act = ActSpareHi;
      if (act == ACT_BACKLIGHT && $urandom_range(3) != 0) v = $urandom_range(1);
      send_cmd(act, v, $urandom(), $urandom());
    end
  endtask

  task automatic run_phase(input logic [15:0] ramp, input int n, input int tick_share,
                           input int ms_span, input logic with_hold);
    int   goal;
    logic held;
    write_ramp(ramp);
    tick_pct    = tick_share;
    ms_step_max = ms_span;
    goal        = cmds_sent + n;
    held        = 1'b0;
    while (cmds_sent < goal) begin
      // halfway through, stall the receiver so the queue backs up
      if (with_hold && !held && cmds_sent >= goal - n / 2) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      send_random_cmd();
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        port_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        port_if.ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  initial begin
    cmd_if.valid  = 1'b0;
    cmd_if.action = ACT_PREPARE;
    cmd_if.value  = '0;
    cmd_if.now_us = '0;
    cmd_if.now_ms = '0;
    port_if.ready = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    cmds_sent     = 0;
    ramp_writes   = 0;
    tick_pct      = 50;
    ms_step_max   = 4;
    us_now        = '0;
    ms_now        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset ramp period, data with rs still low, every action
    send_cmd(ACT_DATA4, 8'hA5, 32'd0, 32'd0);
    send_cmd(ACT_PREPARE, 8'h00, 32'd0, 32'd0);
    send_cmd(ACT_INSTR8, 8'h00, 32'd0, 32'd0);
    send_cmd(ACT_INSTR8, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(ACT_INSTR4, 8'h28, 32'd0, 32'd0);
    send_cmd(ACT_INSTR4, 8'hFF, 32'd0, 32'd0);
    send_cmd(ACT_DATA4, 8'h00, 32'd0, 32'd0);
    send_cmd(ACT_DATA4, 8'hFF, 32'd0, 32'd0);
    send_cmd(ACT_BACKLIGHT, 8'd1, 32'd0, 32'd0);
    send_cmd(ACT_BACKLIGHT, 8'd0, 32'd0, 32'd0);
    // backlight values other than on or off, and spare actions
    send_cmd(ACT_BACKLIGHT, 8'd2, 32'd0, 32'd0);
    send_cmd(ACT_BACKLIGHT, 8'hFF, 32'd0, 32'd0);
    send_cmd(ActSpareLo, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(ActSpareHi, 8'h01, 32'd500, 32'd500);
    // ticks: no gap, gap exactly at threshold, well past, wraparound
    send_cmd(ACT_TICK, 8'h00, 32'd0, 32'd0);
    send_cmd(ACT_TICK, 8'h00, 32'd100, 32'd10);
    send_cmd(ACT_TICK, 8'h00, 32'd201, 32'd21);
    send_cmd(ACT_TICK, 8'h00, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_cmd(ACT_TICK, 8'h00, 32'h0000_0050, 32'h0000_0005);
    send_cmd(ACT_TICK, 8'hFF, 32'h0000_0070, 32'h0000_0010);
    send_cmd(ACT_PREPARE, 8'hFF, 32'd0, 32'd0);
    us_now = 32'h0000_0070;
    ms_now = 32'h0000_0010;

    // random phases over the ramp period range
    run_phase(16'd0, 160, 85, 3, 1'b0);
    run_phase(16'hFFFF, 80, 60, 90000, 1'b0);
    run_phase(16'd10, 80, 45, 8, 1'b1);
    calm = 1'b1;
    run_phase(16'($urandom_range(65535)), 80, 50, 3000, 1'b0);
    calm = 1'b0;
    run_phase(16'd1, 80, 50, 4, 1'b0);
    wait_idle();

    $display("run covered %0d commands across %0d ramp period settings", cmds_sent,
             ramp_writes + 1);
    $display("%0d expander bytes checked, %0d mismatches", chk_bytes, chk_errors);
    if (chk_pending != 0) $display("%0d expected bytes never arrived", chk_pending);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RunLimitNs);
    $display("run timed out");
    $display("Some tests failed");
    $finish;
  end

endmodule
